// File: sv/cbadpcm_pkg.sv
// ----------------------------------------------------------------------------
// Codebook ADPCM decoder package
// Shared widths, codes, types and helper functions of the decoder.
// ----------------------------------------------------------------------------
package cbadpcm_pkg;

   // Store geometry: one page of 16 coefficients per predictor
   localparam int NUM_PREDICTORS = 16;
   localparam int NUM_LANES      = 8;
   localparam int NUM_BANKS      = 2 * NUM_LANES;
   localparam int PAGE_AW        = (NUM_PREDICTORS > 1) ? $clog2(NUM_PREDICTORS) : 1;

   // Datapath widths
   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int ACC_W    = 36;
   localparam int REQ_W    = 72;
   localparam int RSP_W    = NUM_LANES * SAMPLE_W;

   // Multiply-accumulate schedule: two products per lane and step
   localparam int NUM_TERMS = NUM_LANES + 1;
   localparam int MAC_STEPS = (NUM_TERMS + 1) / 2;
   localparam int STEP_W    = $clog2(MAC_STEPS);
   localparam int TERM_W    = STEP_W + 1;

   // Arithmetic constants
   localparam logic [3:0] MAX_SHIFT  = 4'd12;
   localparam int         FRAC_SHIFT = 11;

   // Item kinds
   localparam logic FUNC_DECODE = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type SAT_MAX = 16'sh7fff;
   localparam sample_type SAT_MIN = 16'sh8000;

   typedef sample_type [NUM_BANKS-1:0] coef_vec_type;
   typedef sample_type [NUM_LANES-1:0] sample_vec_type;

   // Per-lane control from the sequencer
   typedef struct packed {
      logic start;
      logic mul_en;
   } lane_ctrl_type;

   // One multiplier operand pair
   typedef struct packed {
      sample_type a;
      sample_type b;
   } term_type;

   // Two operand pairs for one lane step
   typedef struct packed {
      term_type t0;
      term_type t1;
   } lane_ops_type;

   // Expand one 4-bit code: sign-extend, then shift by the clamped scale
   function automatic sample_type scale_code(input logic [3:0] nib, input logic [3:0] scale);
      logic [3:0] sh;
      sample_type n;
      sh = (scale < MAX_SHIFT) ? scale : MAX_SHIFT;
      n  = $signed({{(SAMPLE_W-4){nib[3]}}, nib});
      return n <<< sh;
   endfunction

   // Operand pair of one term of one lane's prediction sum:
   // older history, newer history, then the causal code terms
   function automatic term_type pick_term(input int lane, input logic [TERM_W-1:0] term,
                                          input coef_vec_type coef, input sample_vec_type x,
                                          input sample_type older, input sample_type newer);
      term_type r;
      int       i;
      r.a = '0;
      r.b = '0;
      i   = int'(term) - 2;
      if (term == TERM_W'(0)) begin
         r.a = coef[lane];
         r.b = older;
      end else if (term == TERM_W'(1)) begin
         r.a = coef[NUM_LANES + lane];
         r.b = newer;
      end else if (i < lane) begin
         r.a = coef[NUM_LANES + lane - 1 - i];
         r.b = x[i];
      end
      return r;
   endfunction

endpackage

// File: sv/codebook_adpcm_decoder.sv
// ----------------------------------------------------------------------------
// Codebook ADPCM decoder
// A decode word passes page fetch, five two-multiplier accumulate steps in
// each of the 8 lanes, drain and merge before it shows on rsp; the next
// decode word is taken only after the merge, which waits for the sink.
// Load words are taken one per cycle while idle.
// Reset clears the sequencer, the output valid and the history; the
// codebook holds no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
module codebook_adpcm_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // init[0], scale[4:1], predictor[8:5], codes[40:9], coef_index[48:41],
   // coef_value[64:49], zero[71:65]
   input  logic [cbadpcm_pkg::REQ_W-1:0]   req_tdata,
   // func[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // sample0[15:0], sample1[31:16], ... sample7[127:112]
   output logic [cbadpcm_pkg::RSP_W-1:0]   rsp_tdata
);
   import cbadpcm_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_FETCH  = 5'b00010,
      ST_MAC    = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic             init_ff;
   logic             pred_oob_ff;
   sample_vec_type   x_ff, x_in;

   logic       req_init;
   logic [3:0] req_scale;
   logic [3:0] req_predictor;
   logic [31:0] req_codes;
   logic [7:0] req_coef_index;
   sample_type req_coef_value;

   logic accept, decode_acc, load_acc;
   logic merge_load, out_free;

   coef_vec_type   rd_data, coef_eff;
   sample_type     hist_older, hist_newer, older_eff, newer_eff;
   sample_vec_type samples;
   lane_ctrl_type  lane_ctrl;

   // Unpack the request word
   assign req_init       = req_tdata[0];
   assign req_scale      = req_tdata[4:1];
   assign req_predictor  = req_tdata[8:5];
   assign req_codes      = req_tdata[40:9];
   assign req_coef_index = req_tdata[48:41];
   assign req_coef_value = req_tdata[64:49];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign decode_acc = accept && (req_tuser == FUNC_DECODE);
   assign load_acc   = accept && (req_tuser == FUNC_LOAD);

   // Expand the codes of an incoming half-frame
   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         x_in[k] = scale_code(req_codes[(NUM_LANES-1-k)*4 +: 4], req_scale);
      end
   end

   always_ff @(posedge clock) begin
      if (decode_acc) begin
         x_ff        <= x_in;
         init_ff     <= req_init;
         pred_oob_ff <= ({1'b0, req_predictor} >= 5'(NUM_PREDICTORS));
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (decode_acc) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (step_ff == STEP_W'(MAC_STEPS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign lane_ctrl.start  = (state_ff == ST_FETCH);
   assign lane_ctrl.mul_en = (state_ff == ST_MAC);
   assign merge_load       = (state_ff == ST_FINISH) && out_free;

   // Codebook store
   cbadpcm_book u_book (
      .clock   (clock),
      .wr_en   (load_acc),
      .wr_addr (req_coef_index),
      .wr_data (req_coef_value),
      .rd_en   (decode_acc),
      .rd_page (req_predictor),
      .rd_data (rd_data)
   );

   // Drop coefficients of a missing page, drop history on init
   assign coef_eff  = pred_oob_ff ? '0 : rd_data;
   assign older_eff = init_ff ? '0 : hist_older;
   assign newer_eff = init_ff ? '0 : hist_newer;

   // Sample lanes
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      lane_ops_type ops;

      always_comb begin
         ops.t0 = pick_term(k, {step_ff, 1'b0}, coef_eff, x_ff, older_eff, newer_eff);
         ops.t1 = pick_term(k, {step_ff, 1'b1}, coef_eff, x_ff, older_eff, newer_eff);
      end

      cbadpcm_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .code   (x_ff[k]),
         .ops    (ops),
         .sample (samples[k])
      );
   end

   // Merge lane results into the output word
   cbadpcm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (merge_load),
      .samples    (samples),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .hist_older (hist_older),
      .hist_newer (hist_newer),
      .out_free   (out_free)
   );

   // Checks
   a_decode_reaches_finish: assert property (@(posedge clock) disable iff (reset)
      decode_acc |-> ##8 (state_ff == ST_FINISH))
      else $error("decode did not reach finish on schedule");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> (state_ff == ST_IDLE))
      else $error("coefficient load left idle");

   a_hist_only_on_merge: assert property (@(posedge clock) disable iff (reset)
      !merge_load |=> ($stable(hist_older) && $stable(hist_newer)))
      else $error("history changed without a result");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (step_ff < STEP_W'(MAC_STEPS)))
      else $error("accumulate step out of range");

endmodule

// File: sv/cbadpcm_book.sv
// ----------------------------------------------------------------------------
// Codebook store
// Sixteen coefficient banks, one per tap position, addressed by predictor
// page. One coefficient write and one full-page read per cycle.
// ----------------------------------------------------------------------------
module cbadpcm_book (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [7:0]                 wr_addr,
   input  cbadpcm_pkg::sample_type    wr_data,
   input  logic                       rd_en,
   input  logic [3:0]                 rd_page,
   output cbadpcm_pkg::coef_vec_type  rd_data
);
   import cbadpcm_pkg::*;

   sample_type book_mem [NUM_BANKS][NUM_PREDICTORS];
   sample_type rd_ff    [NUM_BANKS];

   logic [3:0] wr_bank;
   logic [3:0] wr_page;
   logic       wr_page_ok;

   assign wr_bank    = wr_addr[3:0];
   assign wr_page    = wr_addr[7:4];
   assign wr_page_ok = ({1'b0, wr_page} < 5'(NUM_PREDICTORS));

   // Write one coefficient, read a whole page into the output register
   always_ff @(posedge clock) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         if (wr_en && wr_page_ok && (wr_bank == 4'(b))) begin
            book_mem[b][wr_page[PAGE_AW-1:0]] <= wr_data;
         end
         if (rd_en) begin
            rd_ff[b] <= book_mem[b][rd_page[PAGE_AW-1:0]];
         end
      end
   end

   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         rd_data[b] = rd_ff[b];
      end
   end

endmodule

// File: sv/cbadpcm_lane.sv
// ----------------------------------------------------------------------------
// Sample lane
// Two-multiplier accumulate unit for one sample position, with the final
// shift by 11 and saturation to 16 bits.
// ----------------------------------------------------------------------------
module cbadpcm_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  cbadpcm_pkg::lane_ctrl_type   ctrl,
   input  cbadpcm_pkg::sample_type      code,
   input  cbadpcm_pkg::lane_ops_type    ops,
   output cbadpcm_pkg::sample_type      sample
);
   import cbadpcm_pkg::*;

   localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(SAT_MAX);
   localparam logic signed [ACC_W-1:0] LIM_LO = ACC_W'(SAT_MIN);

   logic signed [PROD_W-1:0] prod0_ff, prod1_ff;
   logic signed [PROD_W-1:0] prod0_in, prod1_in;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  shifted;

   // Multiply both operand pairs
   assign prod0_in = ops.t0.a * ops.t0.b;
   assign prod1_in = ops.t1.a * ops.t1.b;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
      end
      acc_ff <= acc_in;
   end

   // Seed with code*2048, then add the registered products
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.start) begin
         acc_in = ACC_W'(code) <<< FRAC_SHIFT;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod0_ff) + ACC_W'(prod1_ff);
      end
   end

   // Scale down and clamp
   assign shifted = acc_ff >>> FRAC_SHIFT;

   always_comb begin
      if (shifted > LIM_HI) begin
         sample = SAT_MAX;
      end else if (shifted < LIM_LO) begin
         sample = SAT_MIN;
      end else begin
         sample = shifted[SAMPLE_W-1:0];
      end
   end

endmodule

// File: sv/cbadpcm_merge.sv
// ----------------------------------------------------------------------------
// Result merge
// Collects the lane samples into the output word, holds it until taken and
// keeps the last two samples as prediction history.
// ----------------------------------------------------------------------------
module cbadpcm_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  cbadpcm_pkg::sample_vec_type     samples,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [cbadpcm_pkg::RSP_W-1:0]   rsp_tdata,
   output cbadpcm_pkg::sample_type         hist_older,
   output cbadpcm_pkg::sample_type         hist_newer,
   output logic                            out_free
);
   import cbadpcm_pkg::*;

   logic             rsp_vld_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   sample_type       older_ff, newer_ff;

   assign out_free = !rsp_vld_ff || rsp_tready;

   // Hold the word until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= samples;
      end
   end

   // Advance history with the last two samples
   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
      end else if (load) begin
         older_ff <= samples[NUM_LANES-2];
         newer_ff <= samples[NUM_LANES-1];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign hist_older = older_ff;
   assign hist_newer = newer_ff;

endmodule
